// ===== rtl/bid_pkg.sv =====
// bid_pkg: shared types and constants of the binary image dilation block
// item structs, opcodes, register indexes, decode kinds, command and status groups
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bid_pkg;

  localparam int ROW_W     = 64;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 64;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CFG_AW-1:0] REG_IMAGE_ROWS  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_COLS  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KERNEL_ROWS = 3'd2;
  localparam logic [CFG_AW-1:0] REG_KERNEL_COLS = 3'd3;
  localparam logic [CFG_AW-1:0] REG_KERNEL_BITS = 3'd4;

  localparam logic [6:0]  IMAGE_ROWS_RST  = 7'd64;
  localparam logic [6:0]  IMAGE_COLS_RST  = 7'd64;
  localparam logic [3:0]  KERNEL_ROWS_RST = 4'd3;
  localparam logic [3:0]  KERNEL_COLS_RST = 4'd3;
  localparam logic [63:0] KERNEL_BITS_RST = 64'd0;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] row_index;
    logic [5:0] col_index;
    logic       pixel;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic             status;
  } out_item_t;

  typedef enum logic [2:0] {
    K_BAD,
    K_NOP,
    K_CLEAR,
    K_STAMP,
    K_READ
  } kind_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic zero_row;
    logic rd_row;
    logic iter_step;
    logic respond;
    logic respond_read;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  iter_last;
    logic  clr_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/bid_ctrl.sv =====
// bid_ctrl: sequencer of the dilation block
// depends on bid_pkg (cmd_t, sts_t, kind_t)
`timescale 1ns / 1ps
`default_nettype none

module bid_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire bid_pkg::sts_t sts,
  output bid_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_READ,
    S_STAMP,
    S_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          bid_pkg::K_CLEAR: begin
            cmd.zero_row = 1'b1;
            cmd.respond  = 1'b1;
            state_nxt    = S_IDLE;
          end
          bid_pkg::K_READ: begin
            cmd.rd_row = 1'b1;
            state_nxt  = S_READ;
          end
          bid_pkg::K_STAMP: begin
            cmd.iter_step = 1'b1;
            state_nxt     = sts.iter_last ? S_DRAIN : S_STAMP;
          end
          default: begin
            cmd.respond = 1'b1;
            state_nxt   = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        cmd.respond_read = 1'b1;
        state_nxt        = S_IDLE;
      end
      S_STAMP: begin
        cmd.iter_step = 1'b1;
        if (sts.iter_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

// ===== rtl/bid_datapath.sv =====
// bid_datapath: config registers, item latch, row memory and stamp pipeline
// depends on bid_pkg (item structs, cmd_t, sts_t, opcodes, register indexes)
`timescale 1ns / 1ps
`default_nettype none

module bid_datapath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int KMAX     = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [bid_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [bid_pkg::CFG_DW-1:0]   cfg_wdata,
  input  wire bid_pkg::in_item_t            in_item,
  input  wire bid_pkg::cmd_t                cmd,
  output bid_pkg::sts_t                     sts,
  output logic                              out_valid,
  output bid_pkg::out_item_t                out_item
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // configuration
  logic [6:0]  image_rows_r, image_cols_r;
  logic [3:0]  kernel_rows_r, kernel_cols_r;
  logic [63:0] kernel_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_rows_r  <= bid_pkg::IMAGE_ROWS_RST;
      image_cols_r  <= bid_pkg::IMAGE_COLS_RST;
      kernel_rows_r <= bid_pkg::KERNEL_ROWS_RST;
      kernel_cols_r <= bid_pkg::KERNEL_COLS_RST;
      kernel_bits_r <= bid_pkg::KERNEL_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        bid_pkg::REG_IMAGE_ROWS:  image_rows_r  <= cfg_wdata[6:0];
        bid_pkg::REG_IMAGE_COLS:  image_cols_r  <= cfg_wdata[6:0];
        bid_pkg::REG_KERNEL_ROWS: kernel_rows_r <= cfg_wdata[3:0];
        bid_pkg::REG_KERNEL_COLS: kernel_cols_r <= cfg_wdata[3:0];
        bid_pkg::REG_KERNEL_BITS: kernel_bits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item latch and iteration counter
  bid_pkg::in_item_t item_r;
  logic [2:0]        it_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      it_r   <= 3'd0;
    end else if (cmd.iter_step) begin
      it_r   <= it_r + 3'd1;
    end
  end

  // effective sizes
  logic [6:0]          cols_eff;
  logic [3:0]          kr, kc;
  logic [2:0]          ar, ac, last_it;
  logic [MAX_COLS-1:0] cmask;
  logic                row_ok, col_ok;

  assign cols_eff = (image_cols_r > 7'(MAX_COLS)) ? 7'(MAX_COLS) : image_cols_r;
  assign kr       = (kernel_rows_r > 4'(KMAX)) ? 4'(KMAX) : kernel_rows_r;
  assign kc       = (kernel_cols_r > 4'(KMAX)) ? 4'(KMAX) : kernel_cols_r;
  assign ar       = kr[3:1];
  assign ac       = kc[3:1];
  assign last_it  = (kr == 4'd0) ? 3'd0 : 3'(kr - 4'd1);

  always_comb begin
    for (int b = 0; b < MAX_COLS; b++) begin
      cmask[b] = (7'(b) < cols_eff);
    end
  end

  assign row_ok = ({1'b0, item_r.row_index} < image_rows_r) &&
                  (int'(item_r.row_index) < MAX_ROWS);
  assign col_ok = {1'b0, item_r.col_index} < cols_eff;

  always_comb begin
    sts.kind = bid_pkg::K_BAD;
    if (row_ok) begin
      case (item_r.opcode)
        bid_pkg::OP_CLEAR: sts.kind = bid_pkg::K_CLEAR;
        bid_pkg::OP_PIXEL: begin
          if (!col_ok)            sts.kind = bid_pkg::K_BAD;
          else if (item_r.pixel)  sts.kind = bid_pkg::K_STAMP;
          else                    sts.kind = bid_pkg::K_NOP;
        end
        bid_pkg::OP_READ:  sts.kind = bid_pkg::K_READ;
        default:           sts.kind = bid_pkg::K_BAD;
      endcase
    end
  end

  assign sts.iter_last = (it_r == last_it);

  // target row and element word of the current iteration
  logic [6:0]          row_sum, tr;
  logic                tr_ok;
  logic [7:0]          krow, kmask, kb;
  logic [71:0]         shifted;
  logic [MAX_COLS-1:0] own_bits, stamp_word;

  assign row_sum = {1'b0, item_r.row_index} + {4'b0, it_r};
  assign tr      = row_sum - {4'b0, ar};
  assign tr_ok   = (row_sum >= {4'b0, ar}) && (tr < image_rows_r) && (int'(tr) < MAX_ROWS);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      kmask[b] = (4'(b) < kc);
    end
  end

  assign krow       = kernel_bits_r[{it_r, 3'b000} +: 8];
  assign kb         = (kr == 4'd0) ? 8'd0 : (krow & kmask);
  assign shifted    = (72'(kb) << item_r.col_index) >> ac;
  // the anchor row also carries the pixel's own cell
  assign own_bits   = (it_r == ar) ? (MAX_COLS'(1) << item_r.col_index) : '0;
  assign stamp_word = (shifted[MAX_COLS-1:0] | own_bits) & cmask;

  // row memory with registered read
  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata_r;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;

  assign rd_en   = cmd.rd_row || (cmd.iter_step && tr_ok);
  assign rd_addr = cmd.rd_row ? AW'(item_r.row_index) : AW'(tr);

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // stamp write stage, one row behind the read
  logic                wr_pend_r;
  logic [AW-1:0]       wr_addr_r;
  logic [MAX_COLS-1:0] wr_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) wr_pend_r <= 1'b0;
    else        wr_pend_r <= cmd.iter_step && tr_ok;
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= AW'(tr);
    wr_word_r <= stamp_word;
  end

  // post-reset clearing sweep
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n)            clr_cnt_r <= '0;
    else if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + AW'(1);
  end

  assign sts.clr_last = (clr_cnt_r == AW'(MAX_ROWS - 1));

  logic                we;
  logic [AW-1:0]       wa;
  logic [MAX_COLS-1:0] wd;

  always_comb begin
    we = 1'b0;
    wa = wr_addr_r;
    wd = rdata_r | wr_word_r;
    if (cmd.clr_step) begin
      we = 1'b1;
      wa = clr_cnt_r;
      wd = '0;
    end else if (cmd.zero_row) begin
      we = 1'b1;
      wa = AW'(item_r.row_index);
      wd = '0;
    end else if (wr_pend_r) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  // result register
  logic               out_valid_r;
  bid_pkg::out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.respond || cmd.respond_read;
  end

  always_ff @(posedge clk) begin
    if (cmd.respond_read) begin
      out_item_r.row_bits <= 64'(rdata_r & cmask);
      out_item_r.status   <= 1'b0;
    end else if (cmd.respond) begin
      out_item_r.row_bits <= '0;
      out_item_r.status   <= (sts.kind == bid_pkg::K_BAD);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/binary_image_dilation.sv =====
// binary_image_dilation: top level of the binary dilation block
// depends on bid_pkg, bid_ctrl, bid_datapath
`timescale 1ns / 1ps
`default_nettype none

// Keeps a dilated bit image as MAX_ROWS row words in a one-read one-write memory.
// An item is taken at a clock edge with start high and busy low; its single result
// is shown on out_item for one cycle with out_valid high and cannot be held off.
// After reset a clearing pass zeroes the memory, one row a cycle, with busy high;
// configuration writes are taken during it.
// Only one item is in flight: busy stays high until the sequencer is back in idle.
// A clear row, clear pixel or ignored request is answered from the decode state;
// a read row passes decode and a read state; a set pixel passes decode, the stamp
// state while element rows remain, then a drain state. The set pixel walks the
// element rows one per cycle, each a read-modify-write of one stored row through
// the memory's read and write ports.
module binary_image_dilation #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int KMAX     = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration write port
  input  wire logic                        cfg_we,
  input  wire logic [bid_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [bid_pkg::CFG_DW-1:0]  cfg_wdata,
  // item input
  input  wire logic                        start,
  output logic                             busy,
  input  wire bid_pkg::in_item_t           in_item,
  // result output
  output logic                             out_valid,
  output bid_pkg::out_item_t               out_item
);

  bid_pkg::cmd_t cmd;
  bid_pkg::sts_t sts;

  // sequencer: post-reset sweep, decode, element row walk, result strobe
  bid_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // config, item latch, row memory, stamp pipeline and result register
  bid_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .KMAX     (KMAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  // a result only appears once the sequencer is back to idle
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // one item in flight, so results never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back to back result strobes");

  // memory and latch commands never collide
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.load, cmd.zero_row, cmd.rd_row, cmd.iter_step}))
    else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire
